FILE: hw/rtl/xrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types and constants for the xoroshiro128+ generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned BOUND_W  = 32;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned HALF_W   = 32;

    // one remainder cell per dividend bit
    localparam int unsigned NUM_CELLS = WORD_W;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] SM_MUL1  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94D0_49BB_1331_11EB;
    localparam int unsigned SM_SHIFT1 = 30;
    localparam int unsigned SM_SHIFT2 = 27;
    localparam int unsigned SM_SHIFT3 = 31;

    // xoroshiro128+ rotation / shift amounts
    localparam int unsigned ROT_A      = 24;
    localparam int unsigned SHIFT_B    = 16;
    localparam int unsigned ROT_C      = 37;
    localparam int unsigned FRAC_SHIFT = 40;

    // request kinds carried on tuser
    localparam logic ACT_SEED = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    // seeder sequencer states
    typedef enum logic [1:0] {
        SD_IDLE,
        SD_ADD,
        SD_MUL,
        SD_FOLD
    } xrg_seed_state_t;

    // seeder -> state word load
    typedef struct packed {
        logic              load_a;
        logic              load_b;
        logic [WORD_W-1:0] word;
    } xrg_load_t;

    // data handed from one remainder cell to the next
    typedef struct packed {
        logic               valid;
        logic [WORD_W-1:0]  raw;
        logic [BOUND_W-1:0] bound;
        logic [BOUND_W-1:0] rem;
    } xrg_cell_t;

endpackage

FILE: hw/rtl/xrg_rem_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_rem_cell
// One restoring-remainder step: shifts in one dividend bit, subtracts bound.
// ----------------------------------------------------------------------------
module xrg_rem_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              dvd_bit,
    input  xrg_pkg::xrg_cell_t cell_in,
    output xrg_pkg::xrg_cell_t cell_out
);

    logic [xrg_pkg::BOUND_W:0]   trial;
    logic [xrg_pkg::BOUND_W:0]   diff;
    logic [xrg_pkg::BOUND_W-1:0] rem_next;
    logic                        valid_reg;
    logic [xrg_pkg::WORD_W-1:0]  raw_reg;
    logic [xrg_pkg::BOUND_W-1:0] bound_reg;
    logic [xrg_pkg::BOUND_W-1:0] rem_reg;

    always_comb begin
        trial = {cell_in.rem, dvd_bit};
        diff  = trial - {1'b0, cell_in.bound};
        if (trial >= {1'b0, cell_in.bound}) begin
            rem_next = diff[xrg_pkg::BOUND_W-1:0];
        end else begin
            rem_next = trial[xrg_pkg::BOUND_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg   <= cell_in.raw;
            bound_reg <= cell_in.bound;
            rem_reg   <= rem_next;
        end
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.raw   = raw_reg;
    assign cell_out.bound = bound_reg;
    assign cell_out.rem   = rem_reg;

endmodule

FILE: hw/rtl/xrg_seed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xrg_seed
// splitmix64 sequencer: two outputs of the seed, one 32x32 multiplier shared.
// ----------------------------------------------------------------------------
module xrg_seed (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [xrg_pkg::WORD_W-1:0] seed,
    output logic                       busy,
    output xrg_pkg::xrg_load_t         load
);

    localparam logic [1:0] PP_LAST = 2'd2;

    xrg_pkg::xrg_seed_state_t state_reg, state_next;
    logic [xrg_pkg::WORD_W-1:0] counter_reg, counter_next;
    logic [xrg_pkg::WORD_W-1:0] z_reg, z_next;
    logic [xrg_pkg::WORD_W-1:0] acc_reg, acc_next;
    logic [1:0]                 pp_reg, pp_next;
    logic                       mul_sel_reg, mul_sel_next;
    logic                       word_sel_reg, word_sel_next;

    logic [xrg_pkg::WORD_W-1:0] gamma_sum;
    logic [xrg_pkg::WORD_W-1:0] mul_k;
    logic [xrg_pkg::HALF_W-1:0] op_x;
    logic [xrg_pkg::HALF_W-1:0] op_y;
    logic [xrg_pkg::WORD_W-1:0] prod;

    // partial products of the low 64 bits: lo*lo, lo*hi<<32, hi*lo<<32
    always_comb begin
        mul_k = mul_sel_reg ? xrg_pkg::SM_MUL2 : xrg_pkg::SM_MUL1;
        case (pp_reg)
            2'd0: begin
                op_x = z_reg[xrg_pkg::HALF_W-1:0];
                op_y = mul_k[xrg_pkg::HALF_W-1:0];
            end
            2'd1: begin
                op_x = z_reg[xrg_pkg::HALF_W-1:0];
                op_y = mul_k[xrg_pkg::WORD_W-1:xrg_pkg::HALF_W];
            end
            default: begin
                op_x = z_reg[xrg_pkg::WORD_W-1:xrg_pkg::HALF_W];
                op_y = mul_k[xrg_pkg::HALF_W-1:0];
            end
        endcase
        prod      = 64'(op_x) * 64'(op_y);
        gamma_sum = counter_reg + xrg_pkg::SM_GAMMA;
    end

    always_comb begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        z_next        = z_reg;
        acc_next      = acc_reg;
        pp_next       = pp_reg;
        mul_sel_next  = mul_sel_reg;
        word_sel_next = word_sel_reg;
        case (state_reg)
            xrg_pkg::SD_IDLE: begin
                if (start) begin
                    counter_next  = seed;
                    word_sel_next = 1'b0;
                    state_next    = xrg_pkg::SD_ADD;
                end
            end
            xrg_pkg::SD_ADD: begin
                counter_next = gamma_sum;
                z_next       = gamma_sum ^ (gamma_sum >> xrg_pkg::SM_SHIFT1);
                mul_sel_next = 1'b0;
                pp_next      = 2'd0;
                state_next   = xrg_pkg::SD_MUL;
            end
            xrg_pkg::SD_MUL: begin
                if (pp_reg == 2'd0) begin
                    acc_next = prod;
                end else begin
                    acc_next = acc_reg + {prod[xrg_pkg::HALF_W-1:0], {xrg_pkg::HALF_W{1'b0}}};
                end
                pp_next = pp_reg + 2'd1;
                if (pp_reg == PP_LAST) begin
                    state_next = xrg_pkg::SD_FOLD;
                end
            end
            xrg_pkg::SD_FOLD: begin
                if (!mul_sel_reg) begin
                    z_next       = acc_reg ^ (acc_reg >> xrg_pkg::SM_SHIFT2);
                    mul_sel_next = 1'b1;
                    pp_next      = 2'd0;
                    state_next   = xrg_pkg::SD_MUL;
                end else if (!word_sel_reg) begin
                    word_sel_next = 1'b1;
                    state_next    = xrg_pkg::SD_ADD;
                end else begin
                    state_next = xrg_pkg::SD_IDLE;
                end
            end
            default: begin
                state_next = xrg_pkg::SD_IDLE;
            end
        endcase
    end

    always_comb begin
        busy        = (state_reg != xrg_pkg::SD_IDLE);
        load.load_a = 1'b0;
        load.load_b = 1'b0;
        load.word   = acc_reg ^ (acc_reg >> xrg_pkg::SM_SHIFT3);
        case (state_reg)
            xrg_pkg::SD_FOLD: begin
                load.load_a = mul_sel_reg && !word_sel_reg;
                load.load_b = mul_sel_reg && word_sel_reg;
            end
            default: begin
                load.load_a = 1'b0;
                load.load_b = 1'b0;
            end
        endcase
    end

    // reset starts a pass with seed zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= xrg_pkg::SD_ADD;
            counter_reg  <= '0;
            pp_reg       <= 2'd0;
            mul_sel_reg  <= 1'b0;
            word_sel_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            counter_reg  <= counter_next;
            pp_reg       <= pp_next;
            mul_sel_reg  <= mul_sel_next;
            word_sel_reg <= word_sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        z_reg   <= z_next;
        acc_reg <= acc_next;
    end

endmodule

FILE: hw/rtl/xoroshiro_random_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoroshiro_random_generator
// xoroshiro128+ (24/16/37) with splitmix64 seeding and a bounded remainder.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Contents
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: action; tdata: seed_value, bound
//  m_      | out | m_tvalid/m_tready  | tdata: raw_value, bounded_value, unit_fraction
//
//  - Draw: accepted at most one per cycle; the result passes through the
//    64-cell remainder chain and then the output register.
//  - Seed: runs in the splitmix64 sequencer (one 32x32 multiplier, three
//    partial products per 64-bit multiply); s_tready is low meanwhile.
//  - Reset: the sequencer runs a seed-zero pass with s_tready low.
//  - Stall: a full output register with m_tready low freezes the whole chain
//    and holds s_tready low.
//
module xoroshiro_random_generator (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // [63:0] seed_value, [95:64] bound
    input  logic         s_tuser,   // [0] action (0 reseed, 1 draw)

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata    // [63:0] raw_value, [95:64] bounded_value,
                                    // [119:96] unit_fraction
);

    localparam int unsigned W  = xrg_pkg::WORD_W;
    localparam int unsigned BW = xrg_pkg::BOUND_W;
    localparam int unsigned N  = xrg_pkg::NUM_CELLS;

    // request handshake
    logic s_accept;
    logic draw_req;
    logic seed_req;
    logic en;           // chain advances
    logic seed_busy;

    xrg_pkg::xrg_load_t load;

    // generator state
    logic [W-1:0] word_a_reg, word_a_next;
    logic [W-1:0] word_b_reg, word_b_next;
    logic [W-1:0] sum;
    logic [W-1:0] mix_b;

    // remainder chain
    xrg_pkg::xrg_cell_t chain [0:N];

    // output register
    logic          m_tvalid_reg;
    logic [W-1:0]  raw_reg;
    logic [BW-1:0] bounded_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && !seed_busy;
    assign s_accept = s_tvalid && s_tready;
    assign draw_req = s_accept && (s_tuser == xrg_pkg::ACT_DRAW);
    assign seed_req = s_accept && (s_tuser == xrg_pkg::ACT_SEED);

    xrg_seed u_seed (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (seed_req),
        .seed    (s_tdata[W-1:0]),
        .busy    (seed_busy),
        .load    (load)
    );

    // xoroshiro128+ step on every draw; sequencer loads while seeding
    always_comb begin
        sum         = word_a_reg + word_b_reg;
        mix_b       = word_a_reg ^ word_b_reg;
        word_a_next = word_a_reg;
        word_b_next = word_b_reg;
        if (load.load_a) begin
            word_a_next = load.word;
        end
        if (load.load_b) begin
            word_b_next = load.word;
        end
        if (draw_req) begin
            word_a_next = ((word_a_reg << xrg_pkg::ROT_A) | (word_a_reg >> (W - xrg_pkg::ROT_A)))
                          ^ mix_b ^ (mix_b << xrg_pkg::SHIFT_B);
            word_b_next = (mix_b << xrg_pkg::ROT_C) | (mix_b >> (W - xrg_pkg::ROT_C));
        end
    end

    always_ff @(posedge aclk) begin
        word_a_reg <= word_a_next;
        word_b_reg <= word_b_next;
    end

    // chain entry: sum is the dividend, partial remainder starts at zero
    assign chain[0].valid = draw_req;
    assign chain[0].raw   = sum;
    assign chain[0].bound = s_tdata[W+BW-1:W];
    assign chain[0].rem   = '0;

    // cell k takes dividend bit W-1-k, MSB first
    for (genvar k = 0; k < N; k++) begin : g_cell
        xrg_rem_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .dvd_bit  (chain[k].raw[W-1-k]),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[N].valid;
        end
    end

    // zero bound gives zero
    always_ff @(posedge aclk) begin
        if (en) begin
            raw_reg     <= chain[N].raw;
            bounded_reg <= (chain[N].bound == '0) ? '0 : chain[N].rem;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {raw_reg[W-1:xrg_pkg::FRAC_SHIFT], bounded_reg, raw_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a seed request blocks the next request while the sequencer runs
    a_seed_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_req |=> !s_tready)
        else $error("request accepted right after a seed request");

    // sequencer never loads a state word in the cycle a draw advances it
    a_no_load_on_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        (load.load_a || load.load_b) |-> !draw_req)
        else $error("state load collides with a draw");

    // finished remainder lies below a nonzero bound
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain[N].valid && (chain[N].bound != '0)) |-> (chain[N].rem < chain[N].bound))
        else $error("remainder not below bound");

    // a stalled chain keeps its result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(chain[N].raw))
        else $error("chain moved during output stall");

endmodule

FILE: dv/xoroshiro_random_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xoroshiro_random_generator_test
// Self-checking bench: a queue-fed driver, an output monitor, and an
// independent xoroshiro128+/splitmix64 predictor that is updated on each
// accepted request and checks every draw's three fields in order.
// ----------------------------------------------------------------------------
module xoroshiro_random_generator_test;

    // own copies of the generator constants, kept apart from the package
    localparam logic [63:0] MIX_STEP   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MULT_1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MULT_2 = 64'h94D0_49BB_1331_11EB;
    localparam int ROT_HI     = 24;
    localparam int XOR_SHIFT  = 16;
    localparam int ROT_LO     = 37;
    localparam int FRAC_POS   = 40;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int TAIL_CYCLES   = 100;
    localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
    localparam int RANDOM_COUNT  = 1400;
    localparam int SEGMENT_COUNT = 8;
    localparam int REPORT_LIMIT  = 10;

    // idling profile, one per stretch of requests
    typedef enum logic [1:0] {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } idle_phase_t;

    typedef struct {
        logic        action;
        logic [63:0] seed;
        logic [31:0] bound;
        idle_phase_t phase;
        bit          drain;   // hold until all outstanding draws are back
    } gen_request_t;

    typedef struct {
        logic [63:0] raw;
        logic [31:0] bounded;
        logic [23:0] frac;
    } draw_result_t;

    logic         aclk;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    gen_request_t request_q[$];
    draw_result_t pending_draws[$];
    gen_request_t active_req;
    idle_phase_t  cur_phase = PH_STEADY;

    // predictor state
    logic [63:0] word_a;
    logic [63:0] word_b;

    int fail_count  = 0;
    int idle_cycles = 0;

    xoroshiro_random_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // splitmix64 finalizer applied to an already advanced counter
    function automatic logic [63:0] splitmix(input logic [63:0] ctr);
        logic [63:0] z;
        z = ctr;
        z = (z ^ (z >> 30)) * MIX_MULT_1;
        z = (z ^ (z >> 27)) * MIX_MULT_2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input int amt);
        return (v << amt) | (v >> (64 - amt));
    endfunction

    // reseed: two successive splitmix outputs fill the state words
    function automatic void load_generator(input logic [63:0] seed);
        word_a = splitmix(seed + MIX_STEP);
        word_b = splitmix(seed + MIX_STEP + MIX_STEP);
    endfunction

    // one accepted request: reseed updates state only, draw queues a result and steps the state
    function automatic void apply_request(input gen_request_t req);
        draw_result_t res;
        logic [63:0]  mixed;
        if (req.action == xrg_pkg::ACT_SEED) begin
            load_generator(req.seed);
        end else begin
            res.raw     = word_a + word_b;
            res.bounded = (req.bound != 0) ? 32'(res.raw % {32'd0, req.bound}) : 32'd0;
            res.frac    = res.raw[FRAC_POS +: 24];
            mixed       = word_b ^ word_a;
            word_a      = rotl(word_a, ROT_HI) ^ mixed ^ (mixed << XOR_SHIFT);
            word_b      = rotl(mixed, ROT_LO);
            pending_draws.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic add_request(input logic act, input logic [63:0] seed,
                               input logic [31:0] bound, input idle_phase_t ph,
                               input bit drain);
        gen_request_t req;
        req.action = act;
        req.seed   = seed;
        req.bound  = bound;
        req.phase  = ph;
        req.drain  = drain;
        request_q.push_back(req);
    endtask

    task automatic add_random_request(input idle_phase_t ph, input bit drain);
        logic [63:0] seed;
        logic [31:0] bound;
        logic        act;
        act = ($urandom_range(99) < 8) ? xrg_pkg::ACT_SEED : xrg_pkg::ACT_DRAW;
        case ($urandom_range(9))
            0: seed = '0;
            1: seed = '1;
            2: seed = 64'd1 << $urandom_range(63);
            default: seed = {$urandom, $urandom};
        endcase
        case ($urandom_range(11))
            0: bound = 32'd0;
            1: bound = 32'd1;
            2: bound = 32'hFFFF_FFFF;
            3: bound = 32'd1 << $urandom_range(31);
            4: bound = (32'd1 << $urandom_range(31)) - 32'd1;
            5: bound = $urandom_range(2, 16);
            6: bound = $urandom_range(17, 1000);
            default: bound = $urandom;
        endcase
        add_request(act, seed, bound, ph, drain);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents requests from request_q, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit sent_now;
        int gap_pct;
        sent_now = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_request(active_req);
                sent_now = 1'b1;
            end
            if (!s_tvalid || sent_now) begin
                gap_pct = 0;
                if (request_q.size() != 0) begin
                    case (request_q[0].phase)
                        PH_SRC_IDLE:  gap_pct = 45;
                        PH_BOTH_IDLE: gap_pct = 25;
                        default:      gap_pct = 0;
                    endcase
                end
                if (request_q.size() != 0
                        && !(request_q[0].drain && pending_draws.size() != 0)
                        && $urandom_range(99) >= gap_pct) begin
                    active_req = request_q.pop_front();
                    cur_phase  = active_req.phase;
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {active_req.bound, active_req.seed};
                    s_tuser   <= active_req.action;
                end else begin
                    s_tvalid  <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: in-order field checks against the predicted draws
    // ------------------------------------------------------------------
    function automatic void report_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        draw_result_t want;
        int stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_draws.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: %h", m_tdata);
                end else begin
                    want = pending_draws.pop_front();
                    report_field("raw_value",     want.raw,           m_tdata[63:0]);
                    report_field("bounded_value", 64'(want.bounded),  64'(m_tdata[95:64]));
                    report_field("unit_fraction", 64'(want.frac),     64'(m_tdata[119:96]));
                end
            end
            case (cur_phase)
                PH_SINK_STALL: stall_pct = 45;
                PH_BOTH_IDLE:  stall_pct = 25;
                default:       stall_pct = 0;
            endcase
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: no handshake on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result moved in %0d cycles", STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        idle_phase_t ph;
        load_generator(64'd0);   // reset state equals a seed-zero reseed

        // directed: reset state, bound extremes, seed extremes, ignored fields
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd0, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd1, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                    PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'h1234_5678_9ABC_DEF0, 32'h8000_0000,
                    PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd3, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_SEED, 64'd0, 32'hFFFF_FFFF, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd2, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd0, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 32'd7, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_SEED, 64'h8000_0000_0000_0000, 32'd5, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_SEED, 64'h0000_0000_0000_0001, 32'd9, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'h5555_5555_5555_5555, 32'h7FFF_FFFF,
                    PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFE,
                    PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd1000, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_SEED, 64'hDEAD_BEEF_0BAD_F00D, 32'd0, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'h0001_0000, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'hFFFF_FFFF, PH_STEADY, 1'b0);
        add_request(xrg_pkg::ACT_DRAW, 64'd0, 32'd0, PH_STEADY, 1'b0);

        // random stretches rotate through the idling profiles; each stretch
        // opens with a pause until all outstanding draws have returned
        for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
            ph = idle_phase_t'(seg % 4);
            for (int i = 0; i < RANDOM_COUNT / SEGMENT_COUNT; i++)
                add_random_request(ph, i == 0);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_draws.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
